// ===== sv/prt_pkg.sv =====
// ---------------------------------------------------------------------------
// prt_pkg: shared types and codes for the process registry table
// Request and result layouts, request and status codes, and the token and
// write-broadcast structs that travel along the chain of table cells.
// ---------------------------------------------------------------------------
package prt_pkg;

    localparam int KEY_W     = 31;
    localparam int CONN_W    = 10;
    localparam int SLOT_W    = 4;
    localparam int ENTRIES_D = 16;

    localparam logic [1:0] REQ_REGISTER   = 2'd0;
    localparam logic [1:0] REQ_CHECK      = 2'd1;
    localparam logic [1:0] REQ_DISCONNECT = 2'd2;

    typedef enum logic [2:0] {
        ST_ADDED   = 3'd0,
        ST_ALREADY = 3'd1,
        ST_FULL    = 3'd2,
        ST_ABSENT  = 3'd3,
        ST_PRESENT = 3'd4
    } t_status;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [KEY_W-1:0]  key;
        logic [CONN_W-1:0] conn_id;
    } t_req;

    typedef struct packed {
        t_status           status;
        logic [SLOT_W-1:0] slot;
    } t_result;

    // Search token handed from cell to cell; slot indexes travel beside it.
    typedef struct packed {
        logic              valid;
        logic [1:0]        req_type;
        logic [KEY_W-1:0]  key;
        logic [CONN_W-1:0] conn_id;
        logic              hit_v;
        logic              empty_v;
        logic              done;
    } t_token;

    // Write broadcast from the top level; the target index travels beside it.
    typedef struct packed {
        logic              en;
        logic [KEY_W-1:0]  key;
        logic [CONN_W-1:0] conn_id;
    } t_wr;

endpackage

// ===== sv/prt_cell.sv =====
// ---------------------------------------------------------------------------
// prt_cell: one slot of the process registry table
// Holds one key and its owner, compares them against the passing search
// token, records the first key match and first empty slot, clears itself on
// the first owner match of a disconnect, and registers the token onward.
// ---------------------------------------------------------------------------
module prt_cell
    import prt_pkg::*;
#(
    parameter int ENTRIES  = ENTRIES_D,
    parameter int CELL_IDX = 0,
    localparam int IW      = $clog2(ENTRIES)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_token        i_tok,
    input  logic [IW-1:0] i_hit_idx,
    input  logic [IW-1:0] i_empty_idx,
    input  t_wr           i_wr,
    input  logic [IW-1:0] i_wr_idx,
    output t_token        o_tok,
    output logic [IW-1:0] o_hit_idx,
    output logic [IW-1:0] o_empty_idx
);

    localparam logic [IW-1:0] MY_IDX = IW'(CELL_IDX);

    logic [KEY_W-1:0]  r_key,  n_key;
    logic [CONN_W-1:0] r_owner, n_owner;
    t_token            r_tok,  n_tok;
    logic [IW-1:0]     r_hit_idx, n_hit_idx;
    logic [IW-1:0]     r_empty_idx, n_empty_idx;

    logic key_eq, is_empty, own_eq, is_search;

    always_comb begin
        key_eq      = (r_key == i_tok.key);
        is_empty    = (r_key == '0);
        own_eq      = (r_owner == i_tok.conn_id);
        is_search   = (i_tok.req_type == REQ_REGISTER) || (i_tok.req_type == REQ_CHECK);
        n_tok       = i_tok;
        n_hit_idx   = i_hit_idx;
        n_empty_idx = i_empty_idx;
        n_key       = r_key;
        n_owner     = r_owner;
        if (i_tok.valid) begin
            if (is_search && key_eq && !i_tok.hit_v) begin
                n_tok.hit_v = 1'b1;
                n_hit_idx   = MY_IDX;
            end
            if (is_empty && !i_tok.empty_v) begin
                n_tok.empty_v = 1'b1;
                n_empty_idx   = MY_IDX;
            end
            // release only the lowest slot owned by this connection
            if (i_tok.req_type == REQ_DISCONNECT && own_eq && !i_tok.done) begin
                n_tok.done = 1'b1;
                n_key      = '0;
                n_owner    = '0;
            end
        end
        if (i_wr.en && i_wr_idx == MY_IDX) begin
            n_key   = i_wr.key;
            n_owner = i_wr.conn_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key       <= '0;
            r_owner     <= '0;
            r_tok.valid <= 1'b0;
        end else begin
            r_key   <= n_key;
            r_owner <= n_owner;
            r_tok   <= n_tok;
        end
        r_hit_idx   <= n_hit_idx;
        r_empty_idx <= n_empty_idx;
    end

    assign o_tok       = r_tok;
    assign o_hit_idx   = r_hit_idx;
    assign o_empty_idx = r_empty_idx;

endmodule

// ===== sv/process_registry_table.sv =====
// ---------------------------------------------------------------------------
// process_registry_table: registration table of process ids
// A request token walks a chain of ENTRIES slot cells, one cell per cycle;
// at the end of the chain the top level answers and writes new entries.
// ---------------------------------------------------------------------------
//  channel   | direction | handshake               | payload
//  request   | in        | start high, busy low    | i_req (req_type, key, conn_id)
//  result    | out       | o_strobe, one cycle     | o_result (status, slot)
//
//  Each transaction runs from accept to result while the token steps through
//  the ENTRIES table cells and the result register; busy stays high meanwhile.
//  Register and check give one result; disconnect and type 3 give none.
//  Synchronous active-low reset empties every slot at once.
//  The receiver cannot stall: each result shows for exactly one cycle.
// ---------------------------------------------------------------------------
module process_registry_table
    import prt_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_D
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_req    i_req,
    output logic    o_strobe,
    output t_result o_result
);

    localparam int IW = $clog2(ENTRIES);

    t_token        tok       [ENTRIES+1];
    logic [IW-1:0] hit_idx   [ENTRIES+1];
    logic [IW-1:0] empty_idx [ENTRIES+1];

    t_wr           wr;
    logic [IW-1:0] wr_idx;

    logic    r_busy, n_busy;
    logic    r_strobe, n_strobe;
    t_result r_result, n_result;

    logic          accept;
    t_token        last;
    logic [IW-1:0] res_idx;
    logic [IW+3:0] res_ext;

    assign accept = start && !r_busy;

    always_comb begin
        tok[0].valid    = accept;
        tok[0].req_type = i_req.req_type;
        tok[0].key      = i_req.key;
        tok[0].conn_id  = i_req.conn_id;
        tok[0].hit_v    = 1'b0;
        tok[0].empty_v  = 1'b0;
        tok[0].done     = 1'b0;
        hit_idx[0]      = '0;
        empty_idx[0]    = '0;
    end

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        prt_cell #(
            .ENTRIES  (ENTRIES),
            .CELL_IDX (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_tok       (tok[g]),
            .i_hit_idx   (hit_idx[g]),
            .i_empty_idx (empty_idx[g]),
            .i_wr        (wr),
            .i_wr_idx    (wr_idx),
            .o_tok       (tok[g+1]),
            .o_hit_idx   (hit_idx[g+1]),
            .o_empty_idx (empty_idx[g+1])
        );
    end

    // Resolve the transaction when the token leaves the last cell.
    always_comb begin
        last       = tok[ENTRIES];
        wr.en      = 1'b0;
        wr.key     = last.key;
        wr.conn_id = last.conn_id;
        wr_idx     = empty_idx[ENTRIES];
        n_strobe   = 1'b0;
        n_busy     = r_busy;
        res_idx    = '0;
        n_result.status = ST_FULL;
        if (accept) begin
            n_busy = 1'b1;
        end
        if (last.valid) begin
            n_busy = 1'b0;
            if (last.req_type == REQ_REGISTER) begin
                n_strobe = 1'b1;
                if (last.hit_v) begin
                    n_result.status = ST_ALREADY;
                    res_idx         = hit_idx[ENTRIES];
                end else if (last.empty_v) begin
                    n_result.status = ST_ADDED;
                    res_idx         = empty_idx[ENTRIES];
                    wr.en           = 1'b1;
                end else begin
                    n_result.status = ST_FULL;
                end
            end else if (last.req_type == REQ_CHECK) begin
                n_strobe = 1'b1;
                if (last.hit_v) begin
                    n_result.status = ST_PRESENT;
                    res_idx         = hit_idx[ENTRIES];
                end else begin
                    n_result.status = ST_ABSENT;
                end
            end
        end
        // slot carries the low four bits of the index
        res_ext       = (IW+4)'(res_idx);
        n_result.slot = res_ext[SLOT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_strobe <= n_strobe;
        end
        r_result <= n_result;
    end

    assign busy     = r_busy;
    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

// ===== sv/prt_checker.sv =====
// ---------------------------------------------------------------------------
// prt_checker: port-level checks for the process registry table
// Watches the command handshake and the result strobe over time.
// ---------------------------------------------------------------------------
module prt_checker
    import prt_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    start,
    input logic    busy,
    input t_req    i_req,
    input logic    o_strobe,
    input t_result o_result
);

    // an accepted transaction carries a fully known request
    a_req_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> !$isunknown(i_req))
        else $error("unknown request fields at accept");

    // an accepted transaction holds busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    // a result only ends a transaction in flight
    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ($past(busy) && !busy))
        else $error("result without a transaction in flight");

    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_result.status == ST_ADDED || o_result.status == ST_ALREADY ||
                      o_result.status == ST_FULL || o_result.status == ST_ABSENT ||
                      o_result.status == ST_PRESENT))
        else $error("illegal result status");

    a_miss_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_result.status == ST_FULL || o_result.status == ST_ABSENT))
            |-> (o_result.slot == '0))
        else $error("nonzero slot on full or absent");

endmodule

bind process_registry_table prt_checker u_prt_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_req    (i_req),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

// ===== sim/tb_process_registry_table.sv =====
// ---------------------------------------------------------------------------
// tb_process_registry_table: self-checking bench for the process id registry
// Drives register, check and disconnect requests through the start/busy
// handshake and compares every strobed result, per field, against a typed
// answer or a behavioral copy of the table in the bench. A short directed
// table covers key and owner extremes, key zero, full and empty tables, then
// a long random run over small key and owner pools keeps the table churning.
// ---------------------------------------------------------------------------
module tb_process_registry_table;
    import prt_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int RST_CYCLES = 11;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_PER_PHASE = 200;
    localparam int MAX_PRINTS = 60;
    localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};
    localparam logic [CONN_W-1:0] CONN_MAX = {CONN_W{1'b1}};

    typedef struct {
        t_req    req;
        bit      typed;
        bit      has_res;
        t_result res;
    } t_stim_row;

    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    logic    busy;
    t_req    i_req;
    logic    o_strobe;
    t_result o_result;

    // typed-in expectation of the transaction currently offered
    bit      row_typed;
    bit      row_has;
    t_result row_res;

    logic [KEY_W-1:0]  key_tbl [ENTRIES_D];
    logic [CONN_W-1:0] owner_tbl [ENTRIES_D];
    t_result           expected_answers [$];
    t_stim_row         dir_rows [$];
    logic [KEY_W-1:0]  key_pool [24];
    logic [CONN_W-1:0] conn_pool [8];

    int unsigned cycles;
    int unsigned mismatches;
    int          idle_pct;

    process_registry_table uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_req    (i_req),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL");
            $finish;
        end
    end

    task automatic report(input string msg);
        if (mismatches < MAX_PRINTS)
            $display("mismatch at cycle %0d: %s", cycles, msg);
        mismatches++;
    endtask

    // Lowest slot holding key k, or -1.
    function automatic int find_slot(input logic [KEY_W-1:0] k);
        for (int i = 0; i < ENTRIES_D; i++)
            if (key_tbl[i] == k)
                return i;
        return -1;
    endfunction

    // Apply one request to the table copy and return the answer it gives.
    function automatic void registry_update(input t_req r, output bit has,
                                            output t_result res);
        int hit;
        has = 1'b0;
        res = '0;
        case (r.req_type)
            REQ_REGISTER: begin
                has = 1'b1;
                hit = find_slot(r.key);
                if (hit >= 0) begin
                    res.status = ST_ALREADY;
                    res.slot   = hit[SLOT_W-1:0];
                end else begin
                    hit = find_slot('0);
                    if (hit >= 0) begin
                        key_tbl[hit]   = r.key;
                        owner_tbl[hit] = r.conn_id;
                        res.status     = ST_ADDED;
                        res.slot       = hit[SLOT_W-1:0];
                    end else begin
                        res.status = ST_FULL;
                    end
                end
            end
            REQ_CHECK: begin
                has = 1'b1;
                hit = find_slot(r.key);
                if (hit >= 0) begin
                    res.status = ST_PRESENT;
                    res.slot   = hit[SLOT_W-1:0];
                end else begin
                    res.status = ST_ABSENT;
                end
            end
            REQ_DISCONNECT: begin
                // release only the lowest slot owned by this connection
                for (int i = 0; i < ENTRIES_D; i++) begin
                    if (owner_tbl[i] == r.conn_id) begin
                        key_tbl[i]   = '0;
                        owner_tbl[i] = '0;
                        break;
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // Result check and expectation bookkeeping, both on the sampled edge.
    always @(posedge i_clk) begin
        bit      has;
        t_result res;
        t_result want;
        if (i_rst_n) begin
            if (o_strobe) begin
                if (expected_answers.size() == 0) begin
                    report($sformatf("unexpected result status %0d slot %0d",
                                     o_result.status, o_result.slot));
                end else begin
                    want = expected_answers.pop_front();
                    if (o_result.status !== want.status)
                        report($sformatf("status %0d, expected %0d",
                                         o_result.status, want.status));
                    if (o_result.slot !== want.slot)
                        report($sformatf("slot %0d, expected %0d",
                                         o_result.slot, want.slot));
                end
            end
            if (start && !busy) begin
                registry_update(i_req, has, res);
                if (row_typed) begin
                    has = row_has;
                    res = row_res;
                end
                if (has)
                    expected_answers.push_back(res);
            end
        end
    end

    // Offer one transaction, hold it until taken, then maybe idle a while.
    task automatic send(input t_req r, input bit typed, input bit has,
                        input t_result res);
        start     <= 1'b1;
        i_req     <= r;
        row_typed <= typed;
        row_has   <= has;
        row_res   <= res;
        do @(posedge i_clk); while (busy);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, ENTRIES_D + 6)) @(posedge i_clk);
        end
    endtask

    function automatic t_stim_row mk_row(input logic [1:0] rt,
                                         input logic [KEY_W-1:0] k,
                                         input logic [CONN_W-1:0] c,
                                         input bit typed, input bit has,
                                         input t_status st,
                                         input logic [SLOT_W-1:0] sl);
        t_stim_row row;
        row.req.req_type = rt;
        row.req.key      = k;
        row.req.conn_id  = c;
        row.typed        = typed;
        row.has_res      = has;
        row.res.status   = st;
        row.res.slot     = sl;
        return row;
    endfunction

    initial begin
        t_req r;
        int   roll;
        int   sent;

        i_clk      = 1'b0;
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_req      = '0;
        row_typed  = 1'b0;
        row_has    = 1'b0;
        row_res    = '0;
        cycles     = 0;
        mismatches = 0;
        idle_pct   = 29;
        for (int i = 0; i < ENTRIES_D; i++) begin
            key_tbl[i]   = '0;
            owner_tbl[i] = '0;
        end

        key_pool[0] = '0;
        key_pool[1] = KEY_MAX;
        for (int i = 2; i < 24; i++)
            key_pool[i] = KEY_W'($urandom);
        conn_pool[0] = '0;
        conn_pool[1] = CONN_MAX;
        for (int i = 2; i < 8; i++)
            conn_pool[i] = CONN_W'($urandom);

        // empty table: key zero matches the first free slot
        dir_rows.push_back(mk_row(REQ_CHECK, '0, '0, 1, 1, ST_PRESENT, 0));
        dir_rows.push_back(mk_row(REQ_REGISTER, KEY_MAX, CONN_MAX, 1, 1, ST_ADDED, 0));
        dir_rows.push_back(mk_row(REQ_REGISTER, KEY_MAX, '0, 1, 1, ST_ALREADY, 0));
        dir_rows.push_back(mk_row(REQ_CHECK, '0, CONN_MAX, 1, 1, ST_PRESENT, 1));
        dir_rows.push_back(mk_row(REQ_UNUSED, KEY_MAX, CONN_MAX, 1, 0, ST_ADDED, 0));
        dir_rows.push_back(mk_row(REQ_DISCONNECT, KEY_MAX, CONN_MAX, 1, 0, ST_ADDED, 0));
        // owner zero matches the already empty slot zero: nothing changes
        dir_rows.push_back(mk_row(REQ_DISCONNECT, '0, '0, 1, 0, ST_ADDED, 0));
        dir_rows.push_back(mk_row(REQ_CHECK, KEY_MAX, '0, 1, 1, ST_ABSENT, 0));
        // fill every slot, slot i owned by connection i
        for (int i = 0; i < ENTRIES_D; i++)
            dir_rows.push_back(mk_row(REQ_REGISTER, KEY_W'(i + 1), CONN_W'(i),
                                      1, 1, ST_ADDED, SLOT_W'(i)));
        dir_rows.push_back(mk_row(REQ_REGISTER, KEY_MAX, CONN_MAX, 1, 1, ST_FULL, 0));
        dir_rows.push_back(mk_row(REQ_CHECK, '0, '0, 1, 1, ST_ABSENT, 0));
        dir_rows.push_back(mk_row(REQ_REGISTER, '0, '0, 1, 1, ST_FULL, 0));
        dir_rows.push_back(mk_row(REQ_DISCONNECT, KEY_MAX, '0, 1, 0, ST_ADDED, 0));
        dir_rows.push_back(mk_row(REQ_CHECK, KEY_W'(1), '0, 1, 1, ST_ABSENT, 0));
        dir_rows.push_back(mk_row(REQ_REGISTER, KEY_W'(31'h5555_5555), CONN_W'(10'h2AA),
                                  0, 0, ST_ADDED, 0));

        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[n])
            send(dir_rows[n].req, dir_rows[n].typed, dir_rows[n].has_res,
                 dir_rows[n].res);

        // random traffic over small pools so keys collide and owners release
        for (int phase = 0; phase < 3; phase++) begin
            idle_pct = (phase == 0) ? 29 : (phase == 1) ? 56 : 0;
            sent = 0;
            while (sent < RANDOM_PER_PHASE) begin
                roll = $urandom_range(0, 99);
                r.req_type = (roll < 42) ? REQ_REGISTER :
                             (roll < 72) ? REQ_CHECK :
                             (roll < 94) ? REQ_DISCONNECT : REQ_UNUSED;
                r.key = ($urandom_range(0, 3) != 0) ? key_pool[$urandom_range(0, 23)]
                                                    : KEY_W'($urandom);
                r.conn_id = ($urandom_range(0, 4) != 0) ? conn_pool[$urandom_range(0, 7)]
                                                        : CONN_W'($urandom);
                send(r, 1'b0, 1'b0, '0);
                if (r.req_type != REQ_UNUSED)
                    sent++;
            end
        end
        start <= 1'b0;

        while (expected_answers.size() != 0)
            @(posedge i_clk);
        repeat (ENTRIES_D + 8) @(posedge i_clk);

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/prt_pkg.sv
sv/prt_cell.sv
sv/process_registry_table.sv
sv/prt_checker.sv
sim/tb_process_registry_table.sv
